// File: design/assert_macros.svh
// assertion macros shared by the business day date adder rtl
// no dependencies; the including module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define BDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define BDA_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/bda_pkg.sv
// shared types, constants and calendar functions for the business day date adder
// no dependencies
`default_nettype none

package bda_pkg;

    localparam int COUNT_BITS = 12;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int WD_W       = 3;
    localparam int QUOT_W     = 8;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [MON_W-1:0]  DEC      = 4'd12;
    localparam logic [MON_W-1:0]  JAN      = 4'd1;
    localparam logic [MON_W-1:0]  FEB      = 4'd2;
    localparam logic [MON_W-1:0]  MAR      = 4'd3;
    localparam logic [WD_W-1:0]   SUNDAY   = 3'd0;
    localparam logic [WD_W-1:0]   SATURDAY = 3'd6;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for y below 43690
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic load;
        logic step;
        logic dec;
        logic set_wd;
    } step_ctl_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] mon,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

    // floor(31 * m / 12) with m the march-based month number
    function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] mon);
        logic [DAY_W-1:0] n;
        unique case (mon)
            4'd1:    n = 5'd28;
            4'd2:    n = 5'd31;
            4'd3:    n = 5'd2;
            4'd4:    n = 5'd5;
            4'd5:    n = 5'd7;
            4'd6:    n = 5'd10;
            4'd7:    n = 5'd12;
            4'd8:    n = 5'd15;
            4'd9:    n = 5'd18;
            4'd10:   n = 5'd20;
            4'd11:   n = 5'd23;
            4'd12:   n = 5'd25;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // 8 = 1 mod 7, so fold octal digits
    function automatic logic [WD_W-1:0] mod7(input logic [YEAR_W-1:0] s);
        logic [4:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        logic [3:0] r;
        f1 = {2'b0, s[2:0]} + {2'b0, s[5:3]} + {2'b0, s[8:6]} + {2'b0, s[11:9]}
           + {3'b0, s[13:12]};
        f2 = {1'b0, f1[2:0]} + {2'b0, f1[4:3]};
        f3 = {1'b0, f2[2:0]} + {3'b0, f2[3]};
        r  = (f3 >= 4'd7) ? f3 - 4'd7 : f3;
        return r[WD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/business_day_date_adder.sv
// top level of the business day date adder: sequencer, weekday setup, result register
// depends on bda_pkg, bda_year_div, bda_date_step and assert_macros.svh
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_stall, start_*, business_days     | in
//  out     | out_valid, out_stall, return_*, bad_start_date,| out
//          | year_overflow                                  |
//
// an item steps through S_DIVY, S_CHECK, S_WSUM, S_WMOD, S_RUN and S_FIN;
// the day stepper advances one calendar day per cycle in S_RUN.
// a bad start date goes from S_CHECK straight to S_FIN.
// reset is asynchronous; no clearing pass, the block is ready right after reset.
// in_stall is high while an item is in work; a result waiting on out_stall holds the
// next item in its final state, S_FIN, only.
`default_nettype none
`include "assert_macros.svh"

module business_day_date_adder
    import bda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DAY_W-1:0]  start_day,
    input  wire logic [MON_W-1:0]  start_month,
    input  wire logic [YEAR_W-1:0] start_year,
    input  wire logic [11:0]       business_days,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DAY_W-1:0]  return_day,
    output logic      [MON_W-1:0]  return_month,
    output logic      [YEAR_W-1:0] return_year,
    output logic      [WD_W-1:0]   return_weekday,
    output logic                   bad_start_date,
    output logic                   year_overflow
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIVY  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_WSUM  = 7'b0001000,
        S_WMOD  = 7'b0010000,
        S_RUN   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    step_ctl_t             ctl;
    logic [DAY_W-1:0]      cur_day;
    logic [MON_W-1:0]      cur_month;
    logic [YEAR_W-1:0]     cur_year;
    logic [WD_W-1:0]       cur_wd;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  step_ovf;

    logic [YEAR_W-1:0] div_in;
    logic [QUOT_W-1:0] quot;
    logic [YEAR_W-1:0] rem100;
    logic              leap;
    logic              jan_feb;
    logic [YEAR_W-1:0] yy;
    logic              start_bad;
    logic              weekend;

    logic [YEAR_W-1:0] sum_reg, sum_next;
    logic              bad_reg, bad_next;
    logic              ovf_reg, ovf_next;

    logic              out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]  out_day_reg;
    logic [MON_W-1:0]  out_month_reg;
    logic [YEAR_W-1:0] out_year_reg;
    logic [WD_W-1:0]   out_wd_reg;
    logic              out_bad_reg;
    logic              out_ovf_reg;
    logic              out_load;

    assign in_stall = !(state_reg == S_IDLE);

    // year arithmetic from the shared divider
    assign jan_feb = cur_month < MAR;
    assign yy      = cur_year - {{(YEAR_W-1){1'b0}}, jan_feb};
    assign div_in  = (state_reg == S_CHECK) ? yy : cur_year;
    assign rem100  = cur_year - (({6'b0, quot} << 6) + ({6'b0, quot} << 5)
                               + ({6'b0, quot} << 2));
    assign leap    = ((cur_year[1:0] == 2'b00) && (rem100 != '0))
                   || ((rem100 == '0) && (quot[1:0] == 2'b00));

    assign start_bad = (cur_month < JAN) || (cur_month > DEC) || (cur_year == '0)
                     || (cur_year > MAX_YEAR) || (cur_day == '0)
                     || (cur_day > days_in_month(cur_month, leap));

    assign weekend = (cur_wd == SUNDAY) || (cur_wd == SATURDAY);

    bda_year_div u_div (
        .clk  (clk),
        .year (div_in),
        .quot (quot)
    );

    bda_date_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .start_count (business_days[COUNT_BITS-1:0]),
        .wd_in       (mod7(sum_reg)),
        .leap        (leap),
        .day         (cur_day),
        .month       (cur_month),
        .year        (cur_year),
        .weekday     (cur_wd),
        .count       (cur_cnt),
        .step_ovf    (step_ovf)
    );

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        sum_next   = sum_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    bad_next   = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (start_bad)
                begin
                    bad_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_WSUM;
                end
            end
            S_WSUM:
            begin
                // quot holds floor(yy / 100) here
                sum_next = {9'b0, cur_day} + yy + (yy >> 2) - {6'b0, quot}
                         + {8'b0, quot[QUOT_W-1:2]} + {9'b0, month_offset(cur_month)};
                state_next = S_WMOD;
            end
            S_WMOD:
            begin
                ctl.set_wd = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cur_cnt != '0)
                begin
                    ctl.step = 1'b1;
                    ctl.dec  = !weekend;
                end
                else if (weekend)
                begin
                    ctl.step = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
                if (ctl.step && step_ovf)
                begin
                    ctl.step   = 1'b0;
                    ovf_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (out_load)
        begin
            out_bad_reg <= bad_reg;
            out_ovf_reg <= ovf_reg;
            if (bad_reg || ovf_reg)
            begin
                out_day_reg   <= '0;
                out_month_reg <= '0;
                out_year_reg  <= '0;
                out_wd_reg    <= '0;
            end
            else
            begin
                out_day_reg   <= cur_day;
                out_month_reg <= cur_month;
                out_year_reg  <= cur_year;
                out_wd_reg    <= cur_wd;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign return_day     = out_day_reg;
    assign return_month   = out_month_reg;
    assign return_year    = out_year_reg;
    assign return_weekday = out_wd_reg;
    assign bad_start_date = out_bad_reg;
    assign year_overflow  = out_ovf_reg;

    `BDA_NEVER(a_flags_exclusive, out_valid && bad_start_date && year_overflow,
        "both error flags set on one result")
    `BDA_ASSERT(a_no_weekend_result,
        (out_valid && !bad_start_date && !year_overflow)
            |-> (return_weekday != SUNDAY && return_weekday != SATURDAY),
        "good result falls on a weekend")
    `BDA_ASSERT(a_accept_starts_work, (in_valid && !in_stall) |=> (state_reg == S_DIVY),
        "accepted beat did not start the sequencer")

endmodule

`default_nettype wire

// File: design/bda_year_div.sv
// shared year divider: registered floor(year / 100) by reciprocal multiply
// depends on bda_pkg
`default_nettype none

module bda_year_div
    import bda_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [YEAR_W-1:0] year,
    output logic      [QUOT_W-1:0] quot
);

    logic [YEAR_W+12:0] prod;
    logic [QUOT_W-1:0]  quot_reg;
    logic [QUOT_W-1:0]  quot_next;

    assign prod      = year * DIV100_MUL;
    assign quot_next = prod[DIV100_SHIFT +: QUOT_W];

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: design/bda_date_step.sv
// calendar datapath: current date, weekday and remaining count, one day per step
// depends on bda_pkg
`default_nettype none

module bda_date_step
    import bda_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire step_ctl_t             ctl,
    input  wire logic [DAY_W-1:0]      start_day,
    input  wire logic [MON_W-1:0]      start_month,
    input  wire logic [YEAR_W-1:0]     start_year,
    input  wire logic [COUNT_BITS-1:0] start_count,
    input  wire logic [WD_W-1:0]       wd_in,
    input  wire logic                  leap,
    output logic      [DAY_W-1:0]      day,
    output logic      [MON_W-1:0]      month,
    output logic      [YEAR_W-1:0]     year,
    output logic      [WD_W-1:0]       weekday,
    output logic      [COUNT_BITS-1:0] count,
    output logic                       step_ovf
);

    logic [DAY_W-1:0]      day_reg,   day_next;
    logic [MON_W-1:0]      month_reg, month_next;
    logic [YEAR_W-1:0]     year_reg,  year_next;
    logic [WD_W-1:0]       wd_reg,    wd_next;
    logic [COUNT_BITS-1:0] cnt_reg,   cnt_next;
    logic                  month_end;

    assign month_end = day_reg >= days_in_month(month_reg, leap);
    assign step_ovf  = month_end && (month_reg >= DEC) && (year_reg >= MAX_YEAR);

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        wd_next    = wd_reg;
        cnt_next   = cnt_reg;
        if (ctl.load)
        begin
            day_next   = start_day;
            month_next = start_month;
            year_next  = start_year;
            cnt_next   = start_count;
        end
        else if (ctl.step)
        begin
            if (month_end)
            begin
                day_next = 5'd1;
                if (month_reg >= DEC)
                begin
                    month_next = JAN;
                    year_next  = year_reg + 14'd1;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
            else
            begin
                day_next = day_reg + 5'd1;
            end
            wd_next = (wd_reg >= SATURDAY) ? SUNDAY : wd_reg + 3'd1;
            if (ctl.dec)
            begin
                cnt_next = cnt_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
        end
        else if (ctl.set_wd)
        begin
            wd_next = wd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        wd_reg    <= wd_next;
    end

    assign day     = day_reg;
    assign month   = month_reg;
    assign year    = year_reg;
    assign weekday = wd_reg;
    assign count   = cnt_reg;

endmodule

`default_nettype wire
